// ===== rtl/hsn_pkg.sv =====
// Shared types, constants and helper functions for the half-shell neighbor enumerator.
// Used by every module in rtl/; depends on nothing.
package hsn_pkg;

	localparam int MAX_CELLS_AXIS_DEF = 64;
	localparam int MAX_REACH_DEF = 2;

	localparam int IMG_CENTER = 13;
	localparam int IMG_SIDE = 3;

	localparam int COORD_W = 6;
	localparam int CELLS_W = 7;
	localparam int REACH_W = 2;
	localparam int WRAP_W = 3;
	localparam int OFF_W = 3;
	localparam int NBR_W = 18;
	localparam int IMG_W = 5;
	localparam int SLOT_W = 6;
	localparam int PROD_W = 2 * CELLS_W;
	localparam int FLAT_W = 3 * CELLS_W;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam int WRAP_X = 0;
	localparam int WRAP_Y = 1;
	localparam int WRAP_Z = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CELLS_X = 3'd0,
		CFG_CELLS_Y = 3'd1,
		CFG_CELLS_Z = 3'd2,
		CFG_REACH_X = 3'd3,
		CFG_REACH_Y = 3'd4,
		CFG_REACH_Z = 3'd5,
		CFG_WRAP    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
	} cell_req_t;

	typedef struct packed {
		logic [NBR_W-1:0]  neighbor_cell;
		logic [IMG_W-1:0]  image_code;
		logic [SLOT_W-1:0] slot;
		logic              last_one;
		logic              coord_error;
	} nbr_rsp_t;

	// Effective grid setup, already saturated.
	typedef struct packed {
		logic [CELLS_W-1:0] cells_x;
		logic [CELLS_W-1:0] cells_y;
		logic [CELLS_W-1:0] cells_z;
		logic [REACH_W-1:0] reach_x;
		logic [REACH_W-1:0] reach_y;
		logic [REACH_W-1:0] reach_z;
		logic [WRAP_W-1:0]  wrap;
	} grid_cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               err;
	} job_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_WALK,
		SQ_END
	} seq_state_t;

	typedef enum logic [1:0] {
		TK_NONE,
		TK_CAND,
		TK_END,
		TK_ERR
	} token_t;

	typedef struct packed {
		logic               ok;
		logic [CELLS_W-1:0] idx;
		logic [1:0]         img;
	} axis_t;

	// Applies one neighbor offset on one axis, wrapping once on a periodic axis.
	// The image offset is -1 after wrapping past the top, +1 after wrapping below zero.
	function automatic axis_t wrap_axis(logic [COORD_W-1:0] coord, logic signed [OFF_W-1:0] off,
			logic [CELLS_W-1:0] dim, logic periodic);
		axis_t r;
		logic signed [CELLS_W+1:0] s;
		logic signed [CELLS_W+1:0] d;
		d = $signed({2'b00, dim});
		s = $signed({{(CELLS_W+2-COORD_W){1'b0}}, coord}) + (CELLS_W+2)'(off);
		r.ok = 1'b1;
		r.img = 2'b00;
		if (s >= d) begin
			if (!periodic) r.ok = 1'b0;
			s = s - d;
			r.img = 2'b11;
		end else if (s < 0) begin
			if (!periodic) r.ok = 1'b0;
			s = s + d;
			r.img = 2'b01;
		end
		if (s < 0 || s >= d) r.ok = 1'b0;
		r.idx = s[CELLS_W-1:0];
		return r;
	endfunction

	// Image code 9*(iz+1) + 3*(iy+1) + (ix+1).
	function automatic logic [IMG_W-1:0] image_code(logic [1:0] ix, logic [1:0] iy, logic [1:0] iz);
		logic [1:0] ux;
		logic [1:0] uy;
		logic [1:0] uz;
		ux = ix + 2'd1;
		uy = iy + 2'd1;
		uz = iz + 2'd1;
		return IMG_W'(IMG_SIDE * IMG_SIDE) * IMG_W'(uz) + IMG_W'(IMG_SIDE) * IMG_W'(uy)
			+ IMG_W'(ux);
	endfunction

endpackage

// ===== rtl/hsn_if.sv =====
// Valid/ready channel interface with a typed payload.
// Depends on nothing; payload types come from hsn_pkg at the instance.
interface hsn_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/hsn_front.sv =====
// Front end: takes a cell request, checks it against the grid and registers a job.
// Depends on hsn_pkg and hsn_if.
module hsn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  hsn_pkg::grid_cfg_t cfg,
	hsn_if.sink               cell_ch,
	hsn_if.source             job_ch
);
	logic           valid_s1;
	hsn_pkg::job_t  job_s1;
	logic           err;

	assign cell_ch.ready = !valid_s1 || job_ch.ready;

	assign err = ({1'b0, cell_ch.payload.cell_x} >= cfg.cells_x)
		|| ({1'b0, cell_ch.payload.cell_y} >= cfg.cells_y)
		|| ({1'b0, cell_ch.payload.cell_z} >= cfg.cells_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_ch.ready) begin
			valid_s1 <= cell_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_ch.valid && cell_ch.ready) begin
			job_s1.x <= cell_ch.payload.cell_x;
			job_s1.y <= cell_ch.payload.cell_y;
			job_s1.z <= cell_ch.payload.cell_z;
			job_s1.err <= err;
		end
	end

	assign job_ch.valid = valid_s1;
	assign job_ch.payload = job_s1;
endmodule

// ===== rtl/hsn_queue.sv =====
// Short job queue between the front end and the neighbor walker.
// Depends on hsn_pkg and hsn_if.
module hsn_queue (
	input  logic clk,
	input  logic arst_n,
	hsn_if.sink   enq,
	hsn_if.source deq
);
	localparam int DEPTH = hsn_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0] FULL = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	hsn_pkg::job_t   entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            push;
	logic            pop;

	assign enq.ready = (count_q != FULL);
	assign deq.valid = (count_q != '0);
	assign deq.payload = entry_q[rd_ptr_q];
	assign push = enq.valid && enq.ready;
	assign pop = deq.valid && deq.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= enq.payload;
		end
	end
endmodule

// ===== rtl/hsn_back.sv =====
// Back end: walks the half shell of one job, one offset a cycle while the output is not stalled,
// computes flat indices in two multiply stages and holds one result back to mark the last one.
// Depends on hsn_pkg and hsn_if.
module hsn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hsn_pkg::grid_cfg_t cfg,
	hsn_if.sink               job_ch,
	hsn_if.source             nbr_ch
);
	localparam int CW = hsn_pkg::CELLS_W;
	localparam int OW = hsn_pkg::OFF_W;

	hsn_pkg::seq_state_t state_q, state_d;
	logic [hsn_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic [1:0]                  kn_q, kn_d;
	logic signed [OW-1:0]        jn_q, jn_d, in_q, in_d;
	logic signed [OW-1:0]        rx, ry;
	hsn_pkg::token_t             token_c, kind_c;
	hsn_pkg::axis_t              ax, ay, az;
	logic                        adv;

	hsn_pkg::token_t             tok_s1, tok_s2, tok_s3;
	logic [CW-1:0]               kk_s1, jj_s1, ii_s1, ii_s2;
	logic [hsn_pkg::IMG_W-1:0]   img_s1, img_s2, img_s3;
	logic [hsn_pkg::PROD_W-1:0]  part_s2;
	logic [hsn_pkg::FLAT_W-1:0]  flat_s3;

	logic                        hold_valid_q;
	logic [hsn_pkg::NBR_W-1:0]   hold_nbr_q;
	logic [hsn_pkg::IMG_W-1:0]   hold_img_q;
	logic [hsn_pkg::SLOT_W-1:0]  hold_slot_q;
	logic [hsn_pkg::SLOT_W-1:0]  cnt_q;
	logic                        out_valid_q;
	hsn_pkg::nbr_rsp_t           out_q;
	logic                        emit;

	// The whole back end moves only when the output register can take a result.
	assign adv = !out_valid_q || nbr_ch.ready;
	assign job_ch.ready = adv && (state_q == hsn_pkg::SQ_IDLE);

	assign rx = $signed({1'b0, cfg.reach_x});
	assign ry = $signed({1'b0, cfg.reach_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsn_pkg::SQ_IDLE;
			kn_q <= '0;
			jn_q <= '0;
			in_q <= '0;
		end else begin
			state_q <= state_d;
			kn_q <= kn_d;
			jn_q <= jn_d;
			in_q <= in_d;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ch.valid && job_ch.ready) begin
			x_q <= job_ch.payload.x;
			y_q <= job_ch.payload.y;
			z_q <= job_ch.payload.z;
		end
	end

	always_comb begin
		state_d = state_q;
		kn_d = kn_q;
		jn_d = jn_q;
		in_d = in_q;
		token_c = hsn_pkg::TK_NONE;
		case (state_q)
			hsn_pkg::SQ_IDLE: begin
				if (job_ch.valid && adv) begin
					if (job_ch.payload.err) begin
						token_c = hsn_pkg::TK_ERR;
					end else begin
						state_d = hsn_pkg::SQ_WALK;
						kn_d = '0;
						jn_d = '0;
						in_d = '0;
					end
				end
			end
			hsn_pkg::SQ_WALK: begin
				if (adv) begin
					token_c = hsn_pkg::TK_CAND;
					if (in_q != rx) begin
						in_d = in_q + OW'(1);
					end else if (jn_q != ry) begin
						jn_d = jn_q + OW'(1);
						// The x range starts at the cell itself only in the z = 0, y = 0 row.
						in_d = (kn_q == '0 && jn_d == '0) ? '0 : -rx;
					end else if (kn_q != cfg.reach_z) begin
						kn_d = kn_q + 2'd1;
						jn_d = -ry;
						in_d = -rx;
					end else begin
						state_d = hsn_pkg::SQ_END;
					end
				end
			end
			hsn_pkg::SQ_END: begin
				if (adv) begin
					token_c = hsn_pkg::TK_END;
					state_d = hsn_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = hsn_pkg::SQ_IDLE;
			end
		endcase
	end

	assign ax = hsn_pkg::wrap_axis(x_q, in_q, cfg.cells_x, cfg.wrap[hsn_pkg::WRAP_X]);
	assign ay = hsn_pkg::wrap_axis(y_q, jn_q, cfg.cells_y, cfg.wrap[hsn_pkg::WRAP_Y]);
	assign az = hsn_pkg::wrap_axis(z_q, $signed({1'b0, kn_q}), cfg.cells_z,
		cfg.wrap[hsn_pkg::WRAP_Z]);

	// Skipped neighbors turn into bubbles here.
	assign kind_c = (token_c == hsn_pkg::TK_CAND && !(ax.ok && ay.ok && az.ok))
		? hsn_pkg::TK_NONE : token_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= hsn_pkg::TK_NONE;
			tok_s2 <= hsn_pkg::TK_NONE;
			tok_s3 <= hsn_pkg::TK_NONE;
		end else if (adv) begin
			tok_s1 <= kind_c;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kk_s1 <= az.idx;
			jj_s1 <= ay.idx;
			ii_s1 <= ax.idx;
			img_s1 <= hsn_pkg::image_code(ax.img, ay.img, az.img);
			part_s2 <= hsn_pkg::PROD_W'(kk_s1) * hsn_pkg::PROD_W'(cfg.cells_y)
				+ hsn_pkg::PROD_W'(jj_s1);
			ii_s2 <= ii_s1;
			img_s2 <= img_s1;
			flat_s3 <= hsn_pkg::FLAT_W'(part_s2) * hsn_pkg::FLAT_W'(cfg.cells_x)
				+ hsn_pkg::FLAT_W'(ii_s2);
			img_s3 <= img_s2;
		end
	end

	// A held neighbor goes out when the next one arrives, or as the last one at the end mark.
	assign emit = (tok_s3 == hsn_pkg::TK_CAND && hold_valid_q) || tok_s3 == hsn_pkg::TK_END
		|| tok_s3 == hsn_pkg::TK_ERR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (tok_s3 == hsn_pkg::TK_CAND) begin
				hold_valid_q <= 1'b1;
				cnt_q <= cnt_q + hsn_pkg::SLOT_W'(1);
			end else if (tok_s3 == hsn_pkg::TK_END) begin
				hold_valid_q <= 1'b0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (tok_s3)
				hsn_pkg::TK_CAND: begin
					out_q <= '{neighbor_cell: hold_nbr_q, image_code: hold_img_q,
						slot: hold_slot_q, last_one: 1'b0, coord_error: 1'b0};
					hold_nbr_q <= flat_s3[hsn_pkg::NBR_W-1:0];
					hold_img_q <= img_s3;
					hold_slot_q <= cnt_q;
				end
				hsn_pkg::TK_END: begin
					out_q <= '{neighbor_cell: hold_nbr_q, image_code: hold_img_q,
						slot: hold_slot_q, last_one: 1'b1, coord_error: 1'b0};
				end
				hsn_pkg::TK_ERR: begin
					out_q <= '{neighbor_cell: '0, image_code: '0, slot: '0,
						last_one: 1'b1, coord_error: 1'b1};
				end
				default: begin
					out_q <= out_q;
				end
			endcase
		end
	end

	assign nbr_ch.valid = out_valid_q;
	assign nbr_ch.payload = out_q;
endmodule

// ===== rtl/half_shell_cell_neighbor_enumerator.sv =====
// Top level of the half-shell neighbor enumerator: grid setup registers, front end,
// job queue and neighbor walker. Depends on hsn_pkg, hsn_if, hsn_front, hsn_queue, hsn_back.
//
//   channel    dir  payload       request moves
//   cell_ch    in   cell_req_t    one cell coordinate triple
//   nbr_ch     out  nbr_rsp_t     one neighbor of the cell, or one error result
//   cfg_*      in   index, data   one setup register write, no handshake
//
// A cell walks each offset of its half shell (14 to 63 for reaches 1..2) in turn; skipped
// neighbors still take their step. An out-of-grid cell yields a single error result.
// Reset sets every axis to one cell, reach one and periodic, and clears all valid state;
// no clearing pass is needed. Results pass the s1, s2, s3 stages and the output register.
// A stall on nbr_ch freezes the walker; the queue keeps taking cells until it fills.
module half_shell_cell_neighbor_enumerator #(
	parameter int MAX_CELLS_AXIS = hsn_pkg::MAX_CELLS_AXIS_DEF,
	parameter int MAX_REACH = hsn_pkg::MAX_REACH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hsn_if.sink                              cell_ch,
	hsn_if.source                            nbr_ch,
	input  logic                             cfg_we,
	input  logic [hsn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hsn_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int CW = hsn_pkg::CELLS_W;
	localparam int RW = hsn_pkg::REACH_W;

	logic [CW-1:0]              cells_x_q, cells_y_q, cells_z_q;
	logic [RW-1:0]              reach_x_q, reach_y_q, reach_z_q;
	logic [hsn_pkg::WRAP_W-1:0] wrap_q;
	hsn_pkg::grid_cfg_t         cfg;

	hsn_if #(.payload_t(hsn_pkg::job_t)) fe_job ();
	hsn_if #(.payload_t(hsn_pkg::job_t)) q_job ();

	function automatic logic [CW-1:0] sat_cells(logic [CW-1:0] v);
		return (int'(v) > MAX_CELLS_AXIS) ? CW'(MAX_CELLS_AXIS) : v;
	endfunction

	function automatic logic [RW-1:0] sat_reach(logic [RW-1:0] v);
		return (v == '0 || int'(v) > MAX_REACH) ? RW'(MAX_REACH) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CW'(1);
			cells_y_q <= CW'(1);
			cells_z_q <= CW'(1);
			reach_x_q <= RW'(1);
			reach_y_q <= RW'(1);
			reach_z_q <= RW'(1);
			wrap_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				hsn_pkg::CFG_CELLS_X: cells_x_q <= cfg_data[CW-1:0];
				hsn_pkg::CFG_CELLS_Y: cells_y_q <= cfg_data[CW-1:0];
				hsn_pkg::CFG_CELLS_Z: cells_z_q <= cfg_data[CW-1:0];
				hsn_pkg::CFG_REACH_X: reach_x_q <= cfg_data[RW-1:0];
				hsn_pkg::CFG_REACH_Y: reach_y_q <= cfg_data[RW-1:0];
				hsn_pkg::CFG_REACH_Z: reach_z_q <= cfg_data[RW-1:0];
				hsn_pkg::CFG_WRAP:    wrap_q <= cfg_data[hsn_pkg::WRAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.cells_x = sat_cells(cells_x_q);
		cfg.cells_y = sat_cells(cells_y_q);
		cfg.cells_z = sat_cells(cells_z_q);
		cfg.reach_x = sat_reach(reach_x_q);
		cfg.reach_y = sat_reach(reach_y_q);
		cfg.reach_z = sat_reach(reach_z_q);
		cfg.wrap = wrap_q;
	end

	hsn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cell_ch (cell_ch),
		.job_ch  (fe_job.source)
	);

	hsn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (fe_job.sink),
		.deq    (q_job.source)
	);

	hsn_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.job_ch (q_job.sink),
		.nbr_ch (nbr_ch)
	);

`ifndef ASSERT_OFF
	a_front_holds_job: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ch.valid && cell_ch.ready |=> fe_job.valid)
		else $error("accepted cell request did not reach the front register");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_ch.valid && nbr_ch.payload.coord_error |->
			nbr_ch.payload.last_one && nbr_ch.payload.slot == '0
			&& nbr_ch.payload.neighbor_cell == '0)
		else $error("error result is not a lone zero result");

	a_first_is_self: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_ch.valid && !nbr_ch.payload.coord_error && nbr_ch.payload.slot == '0 |->
			nbr_ch.payload.image_code == hsn_pkg::IMG_W'(hsn_pkg::IMG_CENTER))
		else $error("first neighbor of a cell carries an image offset");
`endif
endmodule
